FILE: sv/fhbs_pkg.sv
// ----------------------------------------------------------------------------
// fhbs_pkg
// shared types, constants and mix functions of the flow hash bucket selector
// ----------------------------------------------------------------------------
`default_nettype none

package fhbs_pkg;

    // datapath widths
    localparam int WORD_W   = 32;
    localparam int PROTO_W  = 8;
    localparam int BUCKET_W = 7;
    localparam int COUNT_W  = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_SEED    = 1'b0,
        CFG_BUCKET_COUNT = 1'b1
    } t_cfg_idx;

    // bucket count used when the register holds zero or too large a value
    localparam int MAX_BUCKETS = 128;

    // protocol numbers
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // hash initial value terms: golden constant plus a fixed length term
    localparam logic [WORD_W-1:0] HASH_BASE = 32'hdeadbeef;
    localparam logic [WORD_W-1:0] HASH_LEN  = 32'd12;

    // rotate amounts of the final mix
    localparam int ROT_1 = 14;
    localparam int ROT_2 = 11;
    localparam int ROT_3 = 25;
    localparam int ROT_4 = 16;
    localparam int ROT_5 = 4;
    localparam int ROT_6 = 14;
    localparam int ROT_7 = 24;

    // remainder pipeline: quotient bits retired per stage
    localparam int MOD_BITS   = 4;
    localparam int MOD_STAGES = WORD_W / MOD_BITS;

    // valid bit and packet class travelling alongside the data
    typedef struct packed {
        logic valid;
        logic drop;
        logic udp;
    } t_side;

    // rotate left by a constant amount in 1..31
    function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] v,
                                                input int unsigned k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

    // one step of the final mix: p ^= q; p -= rol(q, k)
    function automatic logic [WORD_W-1:0] jmix(input logic [WORD_W-1:0] p,
                                               input logic [WORD_W-1:0] q,
                                               input int unsigned k);
        return (p ^ q) - rol32(q, k);
    endfunction

endpackage

`default_nettype wire

FILE: sv/fhbs_hash.sv
// ----------------------------------------------------------------------------
// fhbs_hash
// five-stage pipeline: key sum, then the seven-step final mix two steps a stage, one in the last stage
// ----------------------------------------------------------------------------
`default_nettype none

module fhbs_hash (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire fhbs_pkg::t_side            i_side,
    input  wire logic [fhbs_pkg::WORD_W-1:0] i_w0,
    input  wire logic [fhbs_pkg::WORD_W-1:0] i_w1,
    input  wire logic [fhbs_pkg::WORD_W-1:0] i_w2,
    input  wire logic [fhbs_pkg::WORD_W-1:0] i_w3,
    input  wire logic [fhbs_pkg::WORD_W-1:0] i_iv,
    output fhbs_pkg::t_side                 o_side,
    output logic [fhbs_pkg::WORD_W-1:0]     o_hash
);

    fhbs_pkg::t_side r_side0, r_side1, r_side2, r_side3, r_side4;

    logic [fhbs_pkg::WORD_W-1:0] r_a0, r_iv0;
    logic [fhbs_pkg::WORD_W-1:0] r_a1, r_b1, r_c1;
    logic [fhbs_pkg::WORD_W-1:0] r_a2, r_b2, r_c2;
    logic [fhbs_pkg::WORD_W-1:0] r_b3, r_c3;
    logic [fhbs_pkg::WORD_W-1:0] r_c4;

    logic [fhbs_pkg::WORD_W-1:0] n_c1, n_b2, n_a3;

    // partial results used inside a stage
    assign n_c1 = fhbs_pkg::jmix(r_iv0, r_iv0, fhbs_pkg::ROT_1);
    assign n_b2 = fhbs_pkg::jmix(r_b1, r_a1, fhbs_pkg::ROT_3);
    assign n_a3 = fhbs_pkg::jmix(r_a2, r_c2, fhbs_pkg::ROT_5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side0 <= '0;
            r_side1 <= '0;
            r_side2 <= '0;
            r_side3 <= '0;
            r_side4 <= '0;
        end else if (i_en) begin
            r_side0 <= i_side;
            r_side1 <= r_side0;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
            r_side4 <= r_side3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // key sum, b and c start at the initial value
            r_a0  <= i_w0 + i_w1 + i_w2 + i_w3 + i_iv;
            r_iv0 <= i_iv;
            // c, a
            r_c1  <= n_c1;
            r_a1  <= fhbs_pkg::jmix(r_a0, n_c1, fhbs_pkg::ROT_2);
            r_b1  <= r_iv0;
            // b, c
            r_b2  <= n_b2;
            r_c2  <= fhbs_pkg::jmix(r_c1, n_b2, fhbs_pkg::ROT_4);
            r_a2  <= r_a1;
            // a, b
            r_b3  <= fhbs_pkg::jmix(r_b2, n_a3, fhbs_pkg::ROT_6);
            r_c3  <= r_c2;
            // last c
            r_c4  <= fhbs_pkg::jmix(r_c3, r_b3, fhbs_pkg::ROT_7);
        end
    end

    assign o_side = r_side4;
    assign o_hash = r_c4;

endmodule

`default_nettype wire

FILE: sv/fhbs_mod.sv
// ----------------------------------------------------------------------------
// fhbs_mod
// pipelined restoring remainder of the hash by the bucket count
// ----------------------------------------------------------------------------
`default_nettype none

module fhbs_mod #(
    parameter int MAX_BUCKETS = fhbs_pkg::MAX_BUCKETS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic [$clog2(MAX_BUCKETS+1)-1:0]     i_count,
    input  wire fhbs_pkg::t_side                      i_side,
    input  wire logic [fhbs_pkg::WORD_W-1:0]          i_hash,
    output fhbs_pkg::t_side                           o_side,
    output logic [$clog2(MAX_BUCKETS+1)-1:0]          o_rem
);

    localparam int CW     = $clog2(MAX_BUCKETS + 1);
    localparam int STAGES = fhbs_pkg::MOD_STAGES;
    localparam int BPS    = fhbs_pkg::MOD_BITS;
    localparam int WW     = fhbs_pkg::WORD_W;

    fhbs_pkg::t_side r_side [STAGES];
    logic [CW-1:0]   r_rem  [STAGES];
    logic [WW-1:0]   r_quo  [STAGES-1];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        fhbs_pkg::t_side w_side_in;
        logic [CW-1:0]   w_rem_in;
        logic [WW-1:0]   w_quo_in;
        logic [CW-1:0]   n_rem;

        if (g == 0) begin : g_first
            assign w_side_in = i_side;
            assign w_rem_in  = '0;
            assign w_quo_in  = i_hash;
        end else begin : g_next
            assign w_side_in = r_side[g-1];
            assign w_rem_in  = r_rem[g-1];
            assign w_quo_in  = r_quo[g-1];
        end

        // shift in four hash bits one at a time, subtract the divisor where it fits
        always_comb begin : p_step
            logic [CW:0]   v_tmp;
            logic [CW-1:0] v_rem;
            v_rem = w_rem_in;
            for (int k = 0; k < BPS; k++) begin
                v_tmp = {v_rem, w_quo_in[WW-1-k]};
                if (v_tmp >= {1'b0, i_count}) begin
                    v_tmp = v_tmp - {1'b0, i_count};
                end
                v_rem = v_tmp[CW-1:0];
            end
            n_rem = v_rem;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[g] <= '0;
            end else if (i_en) begin
                r_side[g] <= w_side_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
            end
        end

        if (g < STAGES - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[g] <= w_quo_in << BPS;
                end
            end
        end
    end

    assign o_side = r_side[STAGES-1];
    assign o_rem  = r_rem[STAGES-1];

endmodule

`default_nettype wire

FILE: sv/flow_hash_bucket_select_core.sv
// an accepted word passes the hash pipeline and then the 8 remainder stages to its result word
// throughput: one word per cycle; the whole pipeline holds only while a result waits
// the remainder pipeline retires 4 hash bits per stage, which sets the 8 stages
// reset: synchronous active low, clears all valid bits; seed reads 0, bucket count 128
// no clearing pass is needed; words are taken on the first cycle after reset
// ----------------------------------------------------------------------------
// flow_hash_bucket_select_core
// classifies packets by protocol, hashes the source address with the final
// mix and reduces the hash modulo the bucket count to pick a backend bucket
// ----------------------------------------------------------------------------
`default_nettype none

module flow_hash_bucket_select_core #(
    parameter int MAX_BUCKETS = fhbs_pkg::MAX_BUCKETS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration writes
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [fhbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fhbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // packet words in
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_is_ipv4,
    input  wire logic [fhbs_pkg::PROTO_W-1:0]      i_ip_proto,
    input  wire logic [fhbs_pkg::WORD_W-1:0]       i_src_word0,
    input  wire logic [fhbs_pkg::WORD_W-1:0]       i_src_word1,
    input  wire logic [fhbs_pkg::WORD_W-1:0]       i_src_word2,
    input  wire logic [fhbs_pkg::WORD_W-1:0]       i_src_word3,
    // result words out
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [fhbs_pkg::BUCKET_W-1:0]          o_bucket,
    output logic                                   o_target_table,
    output logic                                   o_drop
);

    localparam int CW = $clog2(MAX_BUCKETS + 1);

    // configuration: initial value kept pre-added, count kept already saturated
    logic [fhbs_pkg::WORD_W-1:0] r_iv;
    logic [CW-1:0]               r_count_eff;
    logic [CW-1:0]               n_count_eff;
    logic [fhbs_pkg::COUNT_W-1:0] w_cfg_count;

    // pipeline control and data
    logic                        w_en;
    fhbs_pkg::t_side             w_in_side;
    fhbs_pkg::t_side             w_hash_side;
    fhbs_pkg::t_side             w_out_side;
    logic [fhbs_pkg::WORD_W-1:0] w_w1, w_w2, w_w3;
    logic [fhbs_pkg::WORD_W-1:0] w_hash;
    logic [CW-1:0]               w_rem;
    logic [CW+fhbs_pkg::BUCKET_W-1:0] w_rem_ext;
    logic                        w_is_tcp;
    logic                        w_is_udp;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign w_cfg_count = i_cfg_data[fhbs_pkg::COUNT_W-1:0];

    // a count byte of zero or anything above the maximum falls back to the maximum
    always_comb begin
        if ((w_cfg_count == '0) || (32'(w_cfg_count) > 32'(MAX_BUCKETS))) begin
            n_count_eff = CW'(MAX_BUCKETS);
        end else begin
            n_count_eff = CW'(w_cfg_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv        <= fhbs_pkg::HASH_BASE + fhbs_pkg::HASH_LEN;
            r_count_eff <= CW'(MAX_BUCKETS);
        end else if (i_cfg_wr_en) begin
            case (fhbs_pkg::t_cfg_idx'(i_cfg_index))
                fhbs_pkg::CFG_HASH_SEED: begin
                    r_iv <= i_cfg_data + fhbs_pkg::HASH_BASE + fhbs_pkg::HASH_LEN;
                end
                fhbs_pkg::CFG_BUCKET_COUNT: begin
                    r_count_eff <= n_count_eff;
                end
                default: begin
                    r_iv <= r_iv;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: every stage advances together unless a result is held
    // ------------------------------------------------------------------
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // ------------------------------------------------------------------
    // packet classification and key shaping
    // ------------------------------------------------------------------
    assign w_is_tcp = (i_ip_proto == fhbs_pkg::PROTO_TCP);
    assign w_is_udp = (i_ip_proto == fhbs_pkg::PROTO_UDP);

    assign w_in_side.valid = i_valid;
    assign w_in_side.drop  = !(w_is_tcp || w_is_udp);
    assign w_in_side.udp   = w_is_udp;

    // an ipv4 address lives in word 0 only
    assign w_w1 = i_is_ipv4 ? '0 : i_src_word1;
    assign w_w2 = i_is_ipv4 ? '0 : i_src_word2;
    assign w_w3 = i_is_ipv4 ? '0 : i_src_word3;

    // ------------------------------------------------------------------
    // hash and remainder pipelines
    // ------------------------------------------------------------------
    fhbs_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_in_side),
        .i_w0    (i_src_word0),
        .i_w1    (w_w1),
        .i_w2    (w_w2),
        .i_w3    (w_w3),
        .i_iv    (r_iv),
        .o_side  (w_hash_side),
        .o_hash  (w_hash)
    );

    fhbs_mod #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_count (r_count_eff),
        .i_side  (w_hash_side),
        .i_hash  (w_hash),
        .o_side  (w_out_side),
        .o_rem   (w_rem)
    );

    // ------------------------------------------------------------------
    // result word: the last remainder stage is the output register
    // ------------------------------------------------------------------
    assign w_rem_ext      = {{fhbs_pkg::BUCKET_W{1'b0}}, w_rem};
    assign o_valid        = w_out_side.valid;
    assign o_drop         = w_out_side.drop;
    assign o_target_table = w_out_side.udp && !w_out_side.drop;
    assign o_bucket       = w_out_side.drop ? '0 : w_rem_ext[fhbs_pkg::BUCKET_W-1:0];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_eff != '0)
        else $error("effective bucket count is zero");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_drop) |-> (w_rem < r_count_eff))
        else $error("bucket not below the bucket count");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_held_result_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(w_rem) && $stable(o_drop)))
        else $error("held result changed");

endmodule

`default_nettype wire
